// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property check on the rising clock edge, off while reset is asserted.
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Invariant that must hold at every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("invariant violated");

`else

`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_ALWAYS(label, clk, rstn, expr)

`endif

`endif

// ===== rtl/itrd_pkg.sv =====
`default_nettype none

package itrd_pkg;

    localparam int MAG_BITS   = 53;
    localparam int MAX_DIGITS = 56;
    localparam int VAL_W      = MAG_BITS + 1;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int SHIFT_W    = 3;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int DIV_STEPS  = 2;
    localparam int DIV_BITS   = ((MAG_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam int DIV_ITERS  = DIV_BITS / DIV_STEPS;
    localparam int ITER_W     = $clog2(DIV_ITERS);
    localparam int S_TDATA_W  = ((VAL_W + RADIX_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((CHAR_W + 7) / 8) * 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(36);
    localparam logic [CHAR_W-1:0]  MINUS_CHAR = CHAR_W'(8'h2d);
    localparam logic [CHAR_W-1:0]  NO_CHAR    = CHAR_W'(0);

    typedef struct packed {
        logic load;
        logic conv;
        logic load_err;
        logic load_sign;
        logic load_digit;
    } itrd_cmd_t;

    typedef struct packed {
        logic bad_radix;
        logic negative;
        logic digit_ready;
        logic conv_done;
        logic last_digit;
        logic out_free;
    } itrd_sts_t;

    function automatic logic [SHIFT_W-1:0] radix_shift(input logic [RADIX_W-1:0] r);
        logic [SHIFT_W-1:0] s;
        unique case (r)
            RADIX_W'(2):  s = SHIFT_W'(1);
            RADIX_W'(4):  s = SHIFT_W'(2);
            RADIX_W'(8):  s = SHIFT_W'(3);
            RADIX_W'(16): s = SHIFT_W'(4);
            RADIX_W'(32): s = SHIFT_W'(5);
            default:      s = SHIFT_W'(0);
        endcase
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10)) begin
            c = CHAR_W'(8'h30) + CHAR_W'(d);
        end else if (d < DIGIT_W'(36)) begin
            c = CHAR_W'(8'h57) + CHAR_W'(d);
        end else begin
            c = CHAR_W'(8'h30);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/itrd_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module itrd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire itrd_pkg::itrd_sts_t sts,
    output itrd_pkg::itrd_cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ERR  = 6'b000010,
        ST_CONV = 6'b000100,
        ST_SIGN = 6'b001000,
        ST_RD   = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    logic   out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = cmd.load_err || cmd.load_sign || cmd.load_digit;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = accept;
                if (accept) begin
                    state_next = sts.bad_radix ? ST_ERR : ST_CONV;
                end
            end
            ST_ERR: begin
                if (sts.out_free) begin
                    cmd.load_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CONV: begin
                cmd.conv = 1'b1;
                if (sts.digit_ready && sts.conv_done) begin
                    state_next = sts.negative ? ST_SIGN : ST_RD;
                end
            end
            ST_SIGN: begin
                if (sts.out_free) begin
                    cmd.load_sign = 1'b1;
                    state_next    = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load_digit = 1'b1;
                    state_next     = sts.last_digit ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_PROP(a_load_when_free, aclk, aresetn, out_load |-> sts.out_free)
    `ASSERT_PROP(a_bad_goes_err, aclk, aresetn, (accept && sts.bad_radix) |=> (state_reg == ST_ERR))

endmodule

`default_nettype wire

// ===== rtl/itrd_dpath.sv =====
`default_nettype none

`include "assert_macros.svh"

module itrd_dpath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [itrd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire itrd_pkg::itrd_cmd_t              cmd,
    output itrd_pkg::itrd_sts_t                   sts,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [itrd_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tuser
);

    logic [itrd_pkg::VAL_W-1:0]    val_in;
    logic [itrd_pkg::VAL_W-1:0]    neg_val;
    logic [itrd_pkg::RADIX_W-1:0]  radix_in;
    logic [itrd_pkg::MAG_BITS-1:0] mag_in;
    logic                          neg_in;

    logic [itrd_pkg::DIV_BITS-1:0] mag_reg;
    logic [itrd_pkg::DIGIT_W-1:0]  rem_reg;
    logic [itrd_pkg::ITER_W-1:0]   iter_reg;
    logic [itrd_pkg::CNT_W-1:0]    cnt_reg;
    logic [itrd_pkg::RADIX_W-1:0]  radix_reg;
    logic [itrd_pkg::SHIFT_W-1:0]  shift_reg;
    logic                          pow2_reg;
    logic                          neg_reg;

    logic [itrd_pkg::DIV_BITS-1:0] q_div;
    logic [itrd_pkg::DIGIT_W-1:0]  rem_div;
    logic [itrd_pkg::DIV_BITS-1:0] mag_step;
    logic [itrd_pkg::DIGIT_W-1:0]  pow2_digit;
    logic [itrd_pkg::DIGIT_W-1:0]  wr_digit;
    logic [itrd_pkg::CNT_W-1:0]    limit;
    logic [itrd_pkg::CNT_W-1:0]    cnt_inc;
    logic                          wr_en;
    logic [itrd_pkg::ADDR_W-1:0]   rd_addr;

    logic [itrd_pkg::DIGIT_W-1:0]  digit_mem [itrd_pkg::MAX_DIGITS];
    logic [itrd_pkg::DIGIT_W-1:0]  rd_data_reg;

    logic                          out_valid_reg;
    logic [itrd_pkg::CHAR_W-1:0]   out_char_reg;
    logic                          out_last_reg;
    logic                          out_bad_reg;

    assign val_in   = s_tdata[itrd_pkg::VAL_W-1:0];
    assign radix_in = s_tdata[itrd_pkg::VAL_W +: itrd_pkg::RADIX_W];
    assign neg_in   = val_in[itrd_pkg::VAL_W-1];
    assign neg_val  = -val_in;

    // saturate the magnitude of the most negative value
    always_comb begin
        if (!neg_in) begin
            mag_in = val_in[itrd_pkg::MAG_BITS-1:0];
        end else if (neg_val[itrd_pkg::VAL_W-1]) begin
            mag_in = '1;
        end else begin
            mag_in = neg_val[itrd_pkg::MAG_BITS-1:0];
        end
    end

    // restoring division, DIV_STEPS quotient bits per cycle
    always_comb begin
        logic [itrd_pkg::DIGIT_W:0]    rem_w;
        logic [itrd_pkg::DIGIT_W:0]    diff;
        logic [itrd_pkg::DIGIT_W-1:0]  rem_t;
        logic [itrd_pkg::DIV_BITS-1:0] q_t;
        logic                          qbit;
        rem_t = rem_reg;
        q_t   = mag_reg;
        for (int i = 0; i < itrd_pkg::DIV_STEPS; i++) begin
            rem_w = {rem_t, q_t[itrd_pkg::DIV_BITS-1]};
            diff  = rem_w - {1'b0, radix_reg};
            qbit  = (rem_w >= {1'b0, radix_reg});
            rem_t = qbit ? diff[itrd_pkg::DIGIT_W-1:0] : rem_w[itrd_pkg::DIGIT_W-1:0];
            q_t   = {q_t[itrd_pkg::DIV_BITS-2:0], qbit};
        end
        rem_div = rem_t;
        q_div   = q_t;
    end

    assign pow2_digit = mag_reg[itrd_pkg::DIGIT_W-1:0] & (radix_reg - itrd_pkg::RADIX_W'(1));
    assign mag_step   = pow2_reg ? (mag_reg >> shift_reg) : q_div;
    assign wr_digit   = pow2_reg ? pow2_digit : rem_div;
    assign limit      = neg_reg ? itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS - 1)
                                : itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS);
    assign cnt_inc    = cnt_reg + itrd_pkg::CNT_W'(1);
    assign wr_en      = cmd.conv && sts.digit_ready;
    assign rd_addr    = itrd_pkg::ADDR_W'(cnt_reg - itrd_pkg::CNT_W'(1));

    assign sts.bad_radix   = (radix_in < itrd_pkg::RADIX_MIN) || (radix_in > itrd_pkg::RADIX_MAX);
    assign sts.negative    = neg_reg;
    assign sts.digit_ready = pow2_reg || (iter_reg == itrd_pkg::ITER_W'(itrd_pkg::DIV_ITERS - 1));
    assign sts.conv_done   = (mag_step == '0) || (cnt_inc == limit);
    assign sts.last_digit  = (cnt_reg == itrd_pkg::CNT_W'(1));
    assign sts.out_free    = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            iter_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg  <= '0;
            iter_reg <= '0;
        end else if (cmd.conv) begin
            if (sts.digit_ready) begin
                cnt_reg  <= cnt_inc;
                iter_reg <= '0;
            end else begin
                iter_reg <= iter_reg + itrd_pkg::ITER_W'(1);
            end
        end else if (cmd.load_digit) begin
            cnt_reg <= cnt_reg - itrd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg   <= itrd_pkg::DIV_BITS'(mag_in);
            rem_reg   <= '0;
            radix_reg <= radix_in;
            shift_reg <= itrd_pkg::radix_shift(radix_in);
            pow2_reg  <= (itrd_pkg::radix_shift(radix_in) != '0);
            neg_reg   <= neg_in;
        end else if (cmd.conv) begin
            mag_reg <= mag_step;
            rem_reg <= sts.digit_ready ? '0 : rem_div;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_mem[cnt_reg[itrd_pkg::ADDR_W-1:0]] <= wr_digit;
        end
        rd_data_reg <= digit_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_err || cmd.load_sign || cmd.load_digit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_err) begin
            out_char_reg <= itrd_pkg::NO_CHAR;
            out_last_reg <= 1'b0;
            out_bad_reg  <= 1'b1;
        end else if (cmd.load_sign) begin
            out_char_reg <= itrd_pkg::MINUS_CHAR;
            out_last_reg <= 1'b0;
            out_bad_reg  <= 1'b0;
        end else if (cmd.load_digit) begin
            out_char_reg <= itrd_pkg::digit_char(rd_data_reg);
            out_last_reg <= sts.last_digit;
            out_bad_reg  <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = itrd_pkg::M_TDATA_W'(out_char_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

    `ASSERT_PROP(a_rem_below_radix, aclk, aresetn, (cmd.conv && !pow2_reg) |-> (rem_reg < radix_reg))
    `ASSERT_ALWAYS(a_cnt_in_range, aclk, aresetn, cnt_reg <= itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS))

endmodule

`default_nettype wire

// ===== rtl/integer_to_radix_digits_top.sv =====
// Channel  Dir  Fields
// s_       in   tdata: signed_value[53:0], radix[59:54], zero fill to 64 bits
// m_       out  tdata: text_char[6:0], zero fill; tlast: last_char; tuser: bad_radix
//
// One number at a time; s_tready is high only while the block is idle.
// Radix 2, 4, 8, 16, 32: digits by shift and mask. Other radixes use a restoring divider
// (two quotient bits per cycle), up to 34 digits for radix 3.
// Each character then passes through the ST_RD and ST_OUT states for the registered digit memory read.
// A bad radix gives one transfer with tuser set. Synchronous active-low reset.
// m_tready low holds the output register and stalls the character sequence.
`default_nettype none

module integer_to_radix_digits_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [itrd_pkg::S_TDATA_W-1:0] s_tdata,  // signed_value, radix
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [itrd_pkg::M_TDATA_W-1:0]      m_tdata,  // text_char
    output logic                                m_tlast,
    output logic                                m_tuser   // bad_radix
);

    itrd_pkg::itrd_cmd_t cmd;
    itrd_pkg::itrd_sts_t sts;

    itrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itrd_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
